@@ src/assert_macros.svh @@
// assertion macros for the serial flash command engine
// needs a clock named clk and a synchronous reset named rst in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define SFCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every rising edge of clk outside reset
`define SFCE_ASSERT_IMPL(label, ante, cons, msg) \
  `SFCE_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ src/sfce_pkg.sv @@
// types, codes and constants of the serial flash command engine
// used by the front, back and top modules of the block, no dependencies
package sfce_pkg;

  localparam int unsigned ADDRESS_BITS = 24;
  localparam int unsigned PAGE_BYTES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [19:0] POLL_RESET = 20'd500000;

  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_PROG = 8'h02;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_ERASE = 8'h20;
  localparam logic [7:0] CMD_RDID = 8'h9F;
  localparam logic [7:0] FILLER = 8'hFF;
  localparam int unsigned BUSY_BIT = 0;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_code_t;

  typedef enum logic [2:0] {
    OP_RDID  = 3'd0,
    OP_RDSR  = 3'd1,
    OP_WREN  = 3'd2,
    OP_ERASE = 3'd3,
    OP_PROG  = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CK_NONE,
    CK_START,
    CK_BADOP,
    CK_LOAD,
    CK_TICK
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              op;
    logic [ADDRESS_BITS-1:0] address;
    logic [8:0]              count;
    logic [7:0]              buffer_index;
    logic [7:0]              data_byte;
    logic                    miso;
  } in_item_t;

  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       engine_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t               ckind;
    op_t                     op;
    logic [ADDRESS_BITS-1:0] address;
    logic [8:0]              bytes;
    logic                    load_ok;
    logic [7:0]              buffer_index;
    logic [7:0]              data_byte;
    logic                    miso;
  } cmd_t;

endpackage

@@ src/sfce_ram.sv @@
// generic single-write, single-read RAM with registered read data
// no dependencies
module sfce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sfce_fifo.sv @@
// small register queue with count-based full and empty
// no dependencies; depth must be a power of two
module sfce_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

@@ src/sfce_front.sv @@
// front end: classifies incoming transactions and queues them for the back end
// depends on sfce_pkg and sfce_fifo
module sfce_front #(
  parameter int unsigned PAGE_BYTES  = sfce_pkg::PAGE_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = sfce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfce_pkg::in_item_t item,
  output logic              full,
  input  logic              cmd_pop,
  output sfce_pkg::cmd_t    cmd,
  output logic              cmd_empty
);

  sfce_pkg::cmd_t cls;
  logic [$bits(sfce_pkg::cmd_t)-1:0] cmd_bits;

  always_comb begin
    cls.ckind        = sfce_pkg::CK_NONE;
    cls.op           = sfce_pkg::op_t'(item.op);
    cls.address      = item.address;
    cls.bytes        = '0;
    cls.load_ok      = (9'(item.buffer_index) < 9'(PAGE_BYTES));
    cls.buffer_index = item.buffer_index;
    cls.data_byte    = item.data_byte;
    cls.miso         = item.miso;
    case (item.kind)
      sfce_pkg::KIND_START: begin
        cls.ckind = (item.op > sfce_pkg::OP_READ) ? sfce_pkg::CK_BADOP : sfce_pkg::CK_START;
      end
      sfce_pkg::KIND_LOAD: cls.ckind = sfce_pkg::CK_LOAD;
      sfce_pkg::KIND_TICK: cls.ckind = sfce_pkg::CK_TICK;
      default:             cls.ckind = sfce_pkg::CK_NONE;
    endcase
    if (item.op == sfce_pkg::OP_PROG) begin
      cls.bytes = (item.count > 9'(PAGE_BYTES)) ? 9'(PAGE_BYTES) : item.count;
    end else if (item.op == sfce_pkg::OP_READ) begin
      cls.bytes = (item.count > 9'd256) ? 9'd256 : item.count;
    end
  end

  sfce_fifo #(
    .WIDTH($bits(sfce_pkg::cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cls),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmd_bits),
    .empty(cmd_empty)
  );

  assign cmd = sfce_pkg::cmd_t'(cmd_bits);

endmodule

@@ src/sfce_back.sv @@
// back end: runs the serial frame sequencer, one queued transaction per cycle in which go is high
// depends on sfce_pkg and sfce_ram
module sfce_back #(
  parameter int unsigned PAGE_BYTES = sfce_pkg::PAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  sfce_pkg::cmd_t      cmd,
  input  logic [19:0]         poll_limit,
  output sfce_pkg::out_item_t res
);

  localparam int unsigned AW = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WREN,
    PH_MAIN,
    PH_POLL
  } phase_t;

  phase_t      phase, phase_next;
  logic        gap, gap_next;
  sfce_pkg::op_t cur_op, cur_op_next;
  logic [sfce_pkg::ADDRESS_BITS-1:0] op_address, op_address_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [7:0]  tx_shift, tx_shift_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic [3:0]  bit_count, bit_count_next;
  logic        clock_level, clock_level_next;
  logic [19:0] poll_count, poll_count_next;
  logic        cs_n, cs_n_next;
  logic        sclk, sclk_next;
  logic        mosi, mosi_next;

  logic        busy;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [8:0]  ram_index;
  logic [8:0]  len;
  logic [8:0]  bi_inc;
  logic [7:0]  fbyte;
  logic [7:0]  tx_cur;
  logic [7:0]  rx_new;
  logic        rx_hit;

  assign busy = (phase != PH_IDLE);
  assign ram_we = go && (cmd.ckind == sfce_pkg::CK_LOAD) && !busy && cmd.load_ok;
  assign ram_index = byte_index_next - 9'd4;
  assign bi_inc = byte_index + 9'd1;
  assign rx_new = {rx_shift[6:0], cmd.miso};

  sfce_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_BYTES)
  ) u_page (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cmd.buffer_index[AW-1:0]),
    .wdata(cmd.data_byte),
    .raddr(ram_index[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (phase == PH_WREN) begin
      len = 9'd1;
    end else if (phase == PH_POLL) begin
      len = 9'd2;
    end else begin
      case (cur_op)
        sfce_pkg::OP_RDID:  len = 9'd4;
        sfce_pkg::OP_RDSR:  len = 9'd2;
        sfce_pkg::OP_WREN:  len = 9'd1;
        sfce_pkg::OP_ERASE: len = 9'd4;
        default:            len = 9'd4 + bytes_left;
      endcase
    end
  end

  always_comb begin
    fbyte = sfce_pkg::FILLER;
    if (phase == PH_WREN) begin
      fbyte = sfce_pkg::CMD_WREN;
    end else if (phase == PH_POLL) begin
      fbyte = (byte_index == '0) ? sfce_pkg::CMD_RDSR : sfce_pkg::FILLER;
    end else if (byte_index == '0) begin
      case (cur_op)
        sfce_pkg::OP_RDID:  fbyte = sfce_pkg::CMD_RDID;
        sfce_pkg::OP_RDSR:  fbyte = sfce_pkg::CMD_RDSR;
        sfce_pkg::OP_WREN:  fbyte = sfce_pkg::CMD_WREN;
        sfce_pkg::OP_ERASE: fbyte = sfce_pkg::CMD_ERASE;
        sfce_pkg::OP_PROG:  fbyte = sfce_pkg::CMD_PROG;
        sfce_pkg::OP_READ:  fbyte = sfce_pkg::CMD_READ;
        default:            fbyte = sfce_pkg::CMD_RDID;
      endcase
    end else if (cur_op >= sfce_pkg::OP_ERASE && byte_index <= 9'd3) begin
      case (byte_index[1:0])
        2'd1:    fbyte = op_address[23:16];
        2'd2:    fbyte = op_address[15:8];
        default: fbyte = op_address[7:0];
      endcase
    end else if (cur_op == sfce_pkg::OP_PROG) begin
      fbyte = ram_rdata;
    end
  end

  assign tx_cur = (bit_count == '0) ? fbyte : tx_shift;

  always_comb begin
    phase_next       = phase;
    gap_next         = gap;
    cur_op_next      = cur_op;
    op_address_next  = op_address;
    bytes_left_next  = bytes_left;
    byte_index_next  = byte_index;
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    bit_count_next   = bit_count;
    clock_level_next = clock_level;
    poll_count_next  = poll_count;
    cs_n_next        = cs_n;
    sclk_next        = sclk;
    mosi_next        = mosi;
    res              = '0;
    rx_hit           = 1'b0;
    if (go) begin
      case (cmd.ckind)
        sfce_pkg::CK_START: begin
          if (busy) begin
            res.status = sfce_pkg::ST_REJECT;
          end else begin
            cur_op_next      = cmd.op;
            op_address_next  = cmd.address;
            bytes_left_next  = cmd.bytes;
            poll_count_next  = '0;
            rx_shift_next    = '0;
            phase_next       = (cmd.op == sfce_pkg::OP_ERASE || cmd.op == sfce_pkg::OP_PROG)
                               ? PH_WREN : PH_MAIN;
            gap_next         = 1'b0;
            byte_index_next  = '0;
            bit_count_next   = '0;
            clock_level_next = 1'b0;
          end
        end
        sfce_pkg::CK_BADOP: res.status = sfce_pkg::ST_REJECT;
        sfce_pkg::CK_LOAD: begin
          if (busy) begin
            res.status = sfce_pkg::ST_REJECT;
          end
        end
        sfce_pkg::CK_TICK: begin
          if (busy && gap) begin
            sclk_next = 1'b0;
            mosi_next = 1'b0;
            if (!clock_level) begin
              cs_n_next        = 1'b0;
              clock_level_next = 1'b1;
            end else begin
              cs_n_next        = 1'b1;
              clock_level_next = 1'b0;
              gap_next         = 1'b0;
              byte_index_next  = '0;
              bit_count_next   = '0;
              if (phase == PH_WREN) begin
                phase_next = PH_MAIN;
              end else if (phase == PH_MAIN) begin
                if (cur_op == sfce_pkg::OP_ERASE || cur_op == sfce_pkg::OP_PROG) begin
                  poll_count_next = '0;
                  phase_next      = PH_POLL;
                end else begin
                  phase_next   = PH_IDLE;
                  res.done_res = 1'b1;
                end
              end else if (!rx_shift[sfce_pkg::BUSY_BIT]) begin
                phase_next   = PH_IDLE;
                res.done_res = 1'b1;
              end else if (poll_count >= poll_limit) begin
                phase_next   = PH_IDLE;
                res.done_res = 1'b1;
                res.status   = sfce_pkg::ST_TIMEOUT;
              end else begin
                poll_count_next = poll_count + 20'd1;
              end
            end
          end else if (busy && !clock_level) begin
            tx_shift_next    = tx_cur;
            cs_n_next        = 1'b0;
            sclk_next        = 1'b0;
            mosi_next        = tx_cur[7];
            clock_level_next = 1'b1;
          end else if (busy) begin
            sclk_next        = 1'b1;
            rx_shift_next    = rx_new;
            tx_shift_next    = {tx_shift[6:0], 1'b0};
            bit_count_next   = bit_count + 4'd1;
            clock_level_next = 1'b0;
            if (bit_count == 4'd7) begin
              bit_count_next = '0;
              if (phase == PH_MAIN) begin
                if (cur_op == sfce_pkg::OP_RDID || cur_op == sfce_pkg::OP_RDSR) begin
                  rx_hit = (byte_index >= 9'd1);
                end else if (cur_op == sfce_pkg::OP_READ) begin
                  rx_hit = (byte_index >= 9'd4);
                end
              end
              if (rx_hit) begin
                res.rx_valid = 1'b1;
                res.rx_byte  = rx_new;
                res.rx_last  = (bi_inc == len);
              end
              byte_index_next = bi_inc;
              if (bi_inc >= len) begin
                gap_next = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.cs_n        = cs_n_next;
    res.sclk        = sclk_next;
    res.mosi        = mosi_next;
    res.engine_busy = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      gap         <= 1'b0;
      cur_op      <= sfce_pkg::OP_RDID;
      op_address  <= '0;
      bytes_left  <= '0;
      byte_index  <= '0;
      tx_shift    <= '0;
      rx_shift    <= '0;
      bit_count   <= '0;
      clock_level <= 1'b0;
      poll_count  <= '0;
      cs_n        <= 1'b1;
      sclk        <= 1'b0;
      mosi        <= 1'b0;
    end else begin
      phase       <= phase_next;
      gap         <= gap_next;
      cur_op      <= cur_op_next;
      op_address  <= op_address_next;
      bytes_left  <= bytes_left_next;
      byte_index  <= byte_index_next;
      tx_shift    <= tx_shift_next;
      rx_shift    <= rx_shift_next;
      bit_count   <= bit_count_next;
      clock_level <= clock_level_next;
      poll_count  <= poll_count_next;
      cs_n        <= cs_n_next;
      sclk        <= sclk_next;
      mosi        <= mosi_next;
    end
  end

endmodule

@@ src/serial_flash_command_engine.sv @@
// top level of the serial flash command engine: config register, front, back, result queue
// depends on sfce_pkg, sfce_front, sfce_back, sfce_fifo and assert_macros.svh
//
// Mode-0 serial NOR flash master driven by a stream of transactions (start command,
// page buffer load, half-bit tick) with one result per transaction. The block takes
// one transaction per clock as long as the result queue is drained; a transaction is
// held in the input queue, and the sequencer then writes its result straight into the
// result queue, from which it is shown on the result ports. The page buffer is a RAM
// with one registered read port whose address follows the byte counter, so buffered
// program data is ready for the next low half tick. poll_limit is written at address 0;
// the user must write it only while the engine is idle, the block does not enforce it.
`include "assert_macros.svh"

module serial_flash_command_engine #(
  parameter int unsigned PAGE_BYTES  = sfce_pkg::PAGE_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = sfce_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfce_pkg::in_item_t  item,
  output logic                full,
  input  logic                pop,
  output sfce_pkg::out_item_t result,
  output logic                empty,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [19:0]         poll_limit;
  sfce_pkg::cmd_t      cmd;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_full;
  sfce_pkg::out_item_t res;
  logic [$bits(sfce_pkg::out_item_t)-1:0] result_bits;

  assign pready = 1'b1;
  assign prdata = {12'd0, poll_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= sfce_pkg::POLL_RESET;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      poll_limit <= pwdata[19:0];
    end
  end

  sfce_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  assign cmd_pop = !cmd_empty && !res_full;

  sfce_back #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .go        (cmd_pop),
    .cmd       (cmd),
    .poll_limit(poll_limit),
    .res       (res)
  );

  sfce_fifo #(
    .WIDTH($bits(sfce_pkg::out_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_results (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_pop),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(result_bits),
    .empty(empty)
  );

  assign result = sfce_pkg::out_item_t'(result_bits);

  `SFCE_ASSERT_IMPL(a_done_idle, !empty && result.done_res, !result.engine_busy, "done while busy")
  `SFCE_ASSERT_IMPL(a_rx_high, !empty && result.rx_valid, !result.cs_n && result.sclk, "rx off high half")
  `SFCE_ASSERT_IMPL(a_timeout_done, !empty && result.status == sfce_pkg::ST_TIMEOUT, result.done_res, "timeout without done")
  `SFCE_ASSERT_IMPL(a_rx_zero, !empty && !result.rx_valid, result.rx_byte == 8'd0, "stray rx byte")

endmodule
